### design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types, constants and split-rule functions of the pretoken splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   localparam int PositionBits = 16;
   localparam int MaxResults   = 4;
   localparam int CpWidth      = 21;
   localparam int IdxWidth     = 16;
   localparam int CntWidth     = $clog2(MaxResults + 1);

   localparam logic [PositionBits-1:0] PosLimit = {PositionBits{1'b1}};

   typedef logic [CpWidth-1:0]      cp_type;
   typedef logic [PositionBits-1:0] pos_type;
   typedef logic [IdxWidth-1:0]     idx_type;
   typedef logic [CntWidth-1:0]     cnt_type;

   localparam cp_type ChrApos  = 21'h27;
   localparam cp_type ChrSpace = 21'h20;
   localparam cp_type ChrTab   = 21'h09;
   localparam cp_type ChrLf    = 21'h0A;
   localparam cp_type ChrVt    = 21'h0B;
   localparam cp_type ChrFf    = 21'h0C;
   localparam cp_type ChrCr    = 21'h0D;
   localparam cp_type ChrNonAscii = 21'h80;
   localparam cp_type CaseOffset  = 21'd32;
   localparam cp_type ChrUpA = 21'h41;
   localparam cp_type ChrUpZ = 21'h5A;
   localparam cp_type ChrLoA = 21'h61;
   localparam cp_type ChrLoZ = 21'h7A;
   localparam cp_type Chr0   = 21'h30;
   localparam cp_type Chr9   = 21'h39;
   localparam cp_type ChrR   = 21'h72;
   localparam cp_type ChrE   = 21'h65;
   localparam cp_type ChrV   = 21'h76;
   localparam cp_type ChrL   = 21'h6C;
   localparam cp_type ChrS   = 21'h73;
   localparam cp_type ChrT   = 21'h74;
   localparam cp_type ChrM   = 21'h6D;
   localparam cp_type ChrD   = 21'h64;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LETTER,
      MODE_SYM,
      MODE_SYM_NL,
      MODE_SPACE,
      MODE_CONTR_ONE,
      MODE_APOS_WAIT
   } mode_type;

   typedef struct packed {
      cp_type   window;
      logic     fill;
      pos_type  position;
      pos_type  chunk_begin;
      pos_type  after_nl;
      mode_type mode;
      logic     has_nl;
      logic     ovf;
   } state_type;

   typedef struct packed {
      cnt_type                  cnt;
      pos_type [MaxResults-1:0] starts;
      pos_type [MaxResults-1:0] ends;
      logic                     done;
      logic                     ovf;
   } bundle_type;

   function automatic idx_type to_idx(input pos_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[IdxWidth-1:0];
   endfunction

   function automatic logic is_alpha(input cp_type c);
      return (c >= ChrLoA && c <= ChrLoZ) || (c >= ChrUpA && c <= ChrUpZ) ||
             (c >= ChrNonAscii);
   endfunction

   function automatic logic is_digit(input cp_type c);
      return c >= Chr0 && c <= Chr9;
   endfunction

   function automatic logic is_ws(input cp_type c);
      return c == ChrSpace || c == ChrTab || c == ChrLf || c == ChrCr ||
             c == ChrFf || c == ChrVt;
   endfunction

   function automatic logic is_brk(input cp_type c);
      return c == ChrLf || c == ChrCr;
   endfunction

   function automatic logic is_sym(input cp_type c);
      return !is_ws(c) && !is_alpha(c) && !is_digit(c);
   endfunction

   function automatic cp_type fold(input cp_type c);
      return (c >= ChrUpA && c <= ChrUpZ) ? c + CaseOffset : c;
   endfunction

   function automatic logic long_contr(input cp_type a, input cp_type b);
      return (a == ChrR && b == ChrE) || (a == ChrV && b == ChrE) ||
             (a == ChrL && b == ChrL);
   endfunction

   function automatic void emit(inout bundle_type b, input pos_type a, input pos_type e);
      if (b.cnt < cnt_type'(MaxResults)) begin
         b.starts[b.cnt[CntWidth-2:0]] = a;
         b.ends[b.cnt[CntWidth-2:0]]   = e;
         b.cnt = b.cnt + cnt_type'(1);
      end
   endfunction

   function automatic void close_letter(inout state_type s, inout bundle_type b,
                                        input pos_type k, input logic v1,
                                        input cp_type n1);
      if (v1 && is_alpha(n1)) begin
         s.mode = MODE_LETTER;
      end else begin
         emit(b, s.chunk_begin, k + pos_type'(1));
         s.mode = MODE_IDLE;
      end
   endfunction

   function automatic void close_sym(inout state_type s, inout bundle_type b,
                                     input pos_type k, input logic v1, input cp_type n1);
      if (v1 && is_sym(n1)) begin
         s.mode = MODE_SYM;
      end else if (v1 && is_brk(n1)) begin
         s.mode = MODE_SYM_NL;
      end else begin
         emit(b, s.chunk_begin, k + pos_type'(1));
         s.mode = MODE_IDLE;
      end
   endfunction

   function automatic void close_sym_nl(inout state_type s, inout bundle_type b,
                                        input pos_type k, input logic v1,
                                        input cp_type n1);
      if (v1 && is_brk(n1)) begin
         s.mode = MODE_SYM_NL;
      end else begin
         emit(b, s.chunk_begin, k + pos_type'(1));
         s.mode = MODE_IDLE;
      end
   endfunction

   function automatic void space_end(inout state_type s, inout bundle_type b,
                                     input pos_type k, input cp_type c,
                                     input logic v1, input cp_type n1);
      pos_type e;
      pos_type r;
      e = k + pos_type'(1);
      r = s.chunk_begin;
      s.mode = MODE_IDLE;
      if (s.has_nl) begin
         emit(b, s.chunk_begin, s.after_nl);
         r = s.after_nl;
      end
      if (r < e) begin
         if (!v1) begin
            emit(b, r, e);
         end else begin
            if (e - r >= pos_type'(2)) emit(b, r, k);
            s.chunk_begin = k;
            if (is_alpha(n1)) begin
               s.mode = MODE_LETTER;
            end else if (c == ChrSpace && is_sym(n1)) begin
               s.mode = MODE_SYM;
            end else begin
               emit(b, k, e);
            end
         end
      end
   endfunction

   function automatic void absorb_space(inout state_type s, inout bundle_type b,
                                        input pos_type k, input cp_type c,
                                        input logic v1, input cp_type n1);
      if (is_brk(c)) begin
         s.has_nl   = 1'b1;
         s.after_nl = k + pos_type'(1);
      end
      if (v1 && is_ws(n1)) begin
         s.mode = MODE_SPACE;
      end else begin
         space_end(s, b, k, c, v1, n1);
      end
   endfunction

   function automatic void start_chunk(inout state_type s, inout bundle_type b,
                                       input pos_type k, input cp_type c,
                                       input logic v1, input cp_type n1);
      cp_type l;
      logic   done;
      l = fold(n1);
      done = 1'b0;
      s.chunk_begin = k;
      if (c == ChrApos && v1) begin
         if (l == ChrR || l == ChrV || l == ChrL) begin
            s.mode = MODE_APOS_WAIT;
            done = 1'b1;
         end else if (l == ChrS || l == ChrT || l == ChrM || l == ChrD) begin
            s.mode = MODE_CONTR_ONE;
            done = 1'b1;
         end
      end
      if (!done) begin
         if (is_alpha(c)) begin
            close_letter(s, b, k, v1, n1);
         end else if (!is_brk(c) && !is_digit(c) && v1 && is_alpha(n1)) begin
            s.mode = MODE_LETTER;
         end else if (is_digit(c)) begin
            emit(b, k, k + pos_type'(1));
            s.mode = MODE_IDLE;
         end else if (c == ChrSpace && v1 && is_sym(n1)) begin
            s.mode = MODE_SYM;
         end else if (is_sym(c)) begin
            close_sym(s, b, k, v1, n1);
         end else begin
            s.has_nl   = 1'b0;
            s.after_nl = k;
            absorb_space(s, b, k, c, v1, n1);
         end
      end
   endfunction

   function automatic void process(inout state_type s, inout bundle_type b,
                                   input pos_type k, input cp_type c,
                                   input logic v1, input cp_type n1);
      case (s.mode)
         MODE_CONTR_ONE: begin
            emit(b, s.chunk_begin, k + pos_type'(1));
            s.mode = MODE_IDLE;
         end
         MODE_APOS_WAIT: begin
            if (long_contr(fold(c), v1 ? fold(n1) : '0)) s.mode = MODE_CONTR_ONE;
            else close_letter(s, b, k, v1, n1);
         end
         MODE_LETTER: close_letter(s, b, k, v1, n1);
         MODE_SYM:    close_sym(s, b, k, v1, n1);
         MODE_SYM_NL: close_sym_nl(s, b, k, v1, n1);
         MODE_SPACE:  absorb_space(s, b, k, c, v1, n1);
         default:     start_chunk(s, b, k, c, v1, n1);
      endcase
   endfunction

endpackage

`default_nettype wire

### design/pts_step.sv
// ----------------------------------------------------------------------------
// pts_step
// Next-state and chunk results for one accepted codepoint.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_step
   import pts_pkg::*;
(
   input  state_type  cur,
   input  cp_type     codepoint,
   input  logic       text_end,
   output state_type  nxt,
   output bundle_type results
);

   state_type  s;
   bundle_type b;

   always_comb begin
      s = cur;
      b = '0;
      if (s.position < PosLimit) begin
         if (s.fill) process(s, b, s.position - pos_type'(1), s.window, 1'b1, codepoint);
         s.window   = codepoint;
         s.fill     = 1'b1;
         s.position = s.position + pos_type'(1);
      end else begin
         s.ovf = 1'b1;
      end
      if (text_end && s.fill) begin
         process(s, b, s.position - pos_type'(1), s.window, 1'b0, '0);
         s.fill = 1'b0;
      end
      b.done = text_end;
      b.ovf  = s.ovf;
   end

   assign nxt     = text_end ? state_type'('0) : s;
   assign results = b;

endmodule

`default_nettype wire

### design/pts_rsp_queue.sv
// ----------------------------------------------------------------------------
// pts_rsp_queue
// Two-deep queue of result bundles, drained one chunk per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_rsp_queue
   import pts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       space,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output idx_type    rsp_chunk_start,
   output idx_type    rsp_chunk_end,
   output logic       rsp_run_last,
   output logic       rsp_text_done,
   output logic       rsp_overflow
);

   localparam int SelW = CntWidth - 1;

   bundle_type      slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]      cnt_ff, cnt_in, cnt_mid;
   logic [SelW-1:0] sel_ff, sel_in;
   logic            fire, last, pop;

   assign rsp_valid = cnt_ff != 2'd0;
   assign space     = cnt_ff != 2'd2;
   assign fire      = rsp_valid && rsp_ready;
   assign last      = cnt_type'(sel_ff) == slot0_ff.cnt - cnt_type'(1);
   assign pop       = fire && last;

   assign rsp_chunk_start = to_idx(slot0_ff.starts[sel_ff]);
   assign rsp_chunk_end   = to_idx(slot0_ff.ends[sel_ff]);
   assign rsp_run_last    = last;
   assign rsp_text_done   = last && slot0_ff.done;
   assign rsp_overflow    = slot0_ff.ovf;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_mid  = cnt_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         cnt_mid  = cnt_ff - 2'd1;
      end
      cnt_in = cnt_mid;
      if (push) begin
         if (cnt_mid == 2'd0) slot0_in = push_data;
         else slot1_in = push_data;
         cnt_in = cnt_mid + 2'd1;
      end
      if (pop) sel_in = '0;
      else if (fire) sel_in = sel_ff + SelW'(1);
      else sel_in = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sel_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

### design/pretoken_splitter_core.sv
// ----------------------------------------------------------------------------
// pretoken_splitter_core
// Streaming pretokenizer: cuts a codepoint stream into pretoken chunks.
// ----------------------------------------------------------------------------
// usage
//   req channel: one codepoint per transaction, req_text_end on the last one
//   rsp channel: one chunk per transaction as [start, end) codepoint indices;
//     rsp_run_last marks the last chunk caused by a request, rsp_text_done
//     the final chunk of a text, rsp_overflow a text past 65535 codepoints
//   a chunk is reported once a later request settles its end, or on the
//     text_end request; each request's results are registered into the
//     result queue, and a request yields zero to four results
//   throughput: one request per cycle while rsp_ready stays high and each
//     yields at most one result; a request's n results take n transactions
//   a two-deep result queue decouples the sides: req_ready stays high while
//     a finished bundle waits, and drops only when both slots are full
//   reset clears the split state and the queue; the next codepoint opens a
//     new text at index 0, as it does after every text_end
// ----------------------------------------------------------------------------
`default_nettype none

module pretoken_splitter_core
   import pts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  cp_type  req_codepoint,
   input  logic    req_text_end,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output idx_type rsp_chunk_start,
   output idx_type rsp_chunk_end,
   output logic    rsp_run_last,
   output logic    rsp_text_done,
   output logic    rsp_overflow
);

   state_type  st_ff, st_in;
   bundle_type bundle;
   logic       accept, space;

   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   pts_step u_step (
      .cur       (st_ff),
      .codepoint (req_codepoint),
      .text_end  (req_text_end),
      .nxt       (st_in),
      .results   (bundle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   pts_rsp_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (accept && bundle.cnt != '0),
      .push_data       (bundle),
      .space           (space),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chunk_start (rsp_chunk_start),
      .rsp_chunk_end   (rsp_chunk_end),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_done   (rsp_text_done),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives codepoint texts into the pretoken splitter and checks every chunk
// against an in-bench predictor of the split rule, with random idling on both
// channels; a short directed table opens the run, random texts follow.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import pts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] first;
      logic [15:0] last;
      logic        run_last;
      logic        done;
      logic        ovf;
   } chunk_type;

   typedef struct {
      cp_type cp;
      logic   eot;
      logic   typed;
      logic [15:0] first;
      logic [15:0] last;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   cp_type  req_codepoint = '0;
   logic    req_text_end = 1'b0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   idx_type rsp_chunk_start;
   idx_type rsp_chunk_end;
   logic    rsp_run_last;
   logic    rsp_text_done;
   logic    rsp_overflow;

   chunk_type chunk_queue[$];
   int        fail_count = 0;
   bit        feed_done = 1'b0;

   // predictor state
   cp_type      win_cp;
   logic        win_full;
   int unsigned pos_cnt;
   int unsigned begin_idx;
   mode_type    run_state;
   int unsigned nl_after;
   logic        nl_seen;
   logic        ovf_flag;
   int unsigned out_a[$];
   int unsigned out_b[$];

   always #5 clock = ~clock;

   pretoken_splitter_core dut (.*);

   function automatic bit alpha_c(cp_type c);
      return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) || c >= 21'h80;
   endfunction
   function automatic bit digit_c(cp_type c);
      return c >= 21'h30 && c <= 21'h39;
   endfunction
   function automatic bit ws_c(cp_type c);
      return c == 21'h20 || (c >= 21'h09 && c <= 21'h0D);
   endfunction
   function automatic bit nl_c(cp_type c);
      return c == 21'h0A || c == 21'h0D;
   endfunction
   function automatic bit sym_c(cp_type c);
      return !ws_c(c) && !alpha_c(c) && !digit_c(c);
   endfunction
   function automatic cp_type lower_c(cp_type c);
      return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
   endfunction

   function automatic void put_chunk(int unsigned a, int unsigned b);
      if (out_a.size() < MaxResults) begin
         out_a = {out_a, a};
         out_b = {out_b, b};
      end
   endfunction

   function automatic void end_letters(int unsigned k, bit v, cp_type n);
      if (v && alpha_c(n)) run_state = MODE_LETTER;
      else begin
         put_chunk(begin_idx, k + 1);
         run_state = MODE_IDLE;
      end
   endfunction

   function automatic void end_symbols(int unsigned k, bit v, cp_type n, bit nl_only);
      if (v && !nl_only && sym_c(n)) run_state = MODE_SYM;
      else if (v && nl_c(n)) run_state = MODE_SYM_NL;
      else begin
         put_chunk(begin_idx, k + 1);
         run_state = MODE_IDLE;
      end
   endfunction

   function automatic void take_space(int unsigned k, cp_type c, bit v, cp_type n);
      int unsigned e;
      int unsigned r;
      if (nl_c(c)) begin
         nl_seen  = 1'b1;
         nl_after = k + 1;
      end
      if (v && ws_c(n)) begin
         run_state = MODE_SPACE;
         return;
      end
      e = k + 1;
      r = begin_idx;
      run_state = MODE_IDLE;
      if (nl_seen) begin
         put_chunk(begin_idx, nl_after);
         r = nl_after;
      end
      if (r >= e) return;
      if (!v) begin
         put_chunk(r, e);
         return;
      end
      if (e - r >= 2) put_chunk(r, k);
      begin_idx = k;
      if (alpha_c(n)) run_state = MODE_LETTER;
      else if (c == ChrSpace && sym_c(n)) run_state = MODE_SYM;
      else put_chunk(k, e);
   endfunction

   function automatic void classify(int unsigned k, cp_type c, bit v, cp_type n);
      cp_type l;
      l = lower_c(n);
      case (run_state)
         MODE_CONTR_ONE: begin
            put_chunk(begin_idx, k + 1);
            run_state = MODE_IDLE;
         end
         MODE_APOS_WAIT: begin
            if (long_contr(lower_c(c), v ? l : '0)) run_state = MODE_CONTR_ONE;
            else end_letters(k, v, n);
         end
         MODE_LETTER: end_letters(k, v, n);
         MODE_SYM:    end_symbols(k, v, n, 1'b0);
         MODE_SYM_NL: end_symbols(k, v, n, 1'b1);
         MODE_SPACE:  take_space(k, c, v, n);
         default: begin
            begin_idx = k;
            if (c == ChrApos && v && (l == ChrR || l == ChrV || l == ChrL))
               run_state = MODE_APOS_WAIT;
            else if (c == ChrApos && v && (l == ChrS || l == ChrT || l == ChrM || l == ChrD))
               run_state = MODE_CONTR_ONE;
            else if (alpha_c(c)) end_letters(k, v, n);
            else if (!nl_c(c) && !digit_c(c) && v && alpha_c(n)) run_state = MODE_LETTER;
            else if (digit_c(c)) put_chunk(k, k + 1);
            else if (c == ChrSpace && v && sym_c(n)) run_state = MODE_SYM;
            else if (sym_c(c)) end_symbols(k, v, n, 1'b0);
            else begin
               nl_seen  = 1'b0;
               nl_after = k;
               take_space(k, c, v, n);
            end
         end
      endcase
   endfunction

   function automatic void clear_text();
      win_cp = '0;
      win_full = 1'b0;
      pos_cnt = 0;
      begin_idx = 0;
      run_state = MODE_IDLE;
      nl_after = 0;
      nl_seen = 1'b0;
      ovf_flag = 1'b0;
   endfunction

   function automatic void predict_chunks(cp_type c, logic eot);
      chunk_type ch;
      out_a.delete();
      out_b.delete();
      if (pos_cnt < 65535) begin
         if (win_full) classify(pos_cnt - 1, win_cp, 1'b1, c);
         win_cp = c;
         win_full = 1'b1;
         pos_cnt++;
      end else begin
         ovf_flag = 1'b1;
      end
      if (eot && win_full) begin
         classify(pos_cnt - 1, win_cp, 1'b0, '0);
         win_full = 1'b0;
      end
      foreach (out_a[i]) begin
         ch.first    = out_a[i][15:0];
         ch.last     = out_b[i][15:0];
         ch.run_last = (i == out_a.size() - 1);
         ch.done     = ch.run_last && eot;
         ch.ovf      = ovf_flag;
         chunk_queue = {chunk_queue, ch};
      end
      if (eot) clear_text();
   endfunction

   task automatic send_cp(cp_type c, logic eot);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_codepoint <= c;
      req_text_end  <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_chunks(c, eot);
   endtask

   function automatic cp_type pick_cp();
      case ($urandom_range(0, 11))
         0: return cp_type'($urandom_range(21'h61, 21'h7A));
         1: return cp_type'($urandom_range(21'h41, 21'h5A));
         2: return cp_type'($urandom_range(21'h30, 21'h39));
         3, 4: return ChrSpace;
         5: return cp_type'($urandom_range(21'h09, 21'h0D));
         6: return ChrApos;
         7: begin
            case ($urandom_range(0, 7))
               0: return ChrS; 1: return ChrT; 2: return ChrR; 3: return ChrE;
               4: return ChrV; 5: return ChrL; 6: return ChrM; default: return ChrD;
            endcase
         end
         8: return cp_type'($urandom_range(21'h21, 21'h2F));
         9: return cp_type'($urandom_range(21'h3A, 21'h40));
         10: return cp_type'($urandom_range(21'h80, 21'h1FFFFF));
         default: return cp_type'($urandom_range(0, 21'h7F));
      endcase
   endfunction

   // results side
   initial begin
      chunk_type exp_c;
      int        stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (chunk_queue.size() == 0) begin
            $error("unexpected transaction start=%0d end=%0d",
                   rsp_chunk_start, rsp_chunk_end);
            fail_count++;
         end else begin
            exp_c = chunk_queue.pop_front();
            if (rsp_chunk_start !== exp_c.first) begin
               $error("chunk_start exp %0d got %0d", exp_c.first, rsp_chunk_start);
               fail_count++;
            end
            if (rsp_chunk_end !== exp_c.last) begin
               $error("chunk_end exp %0d got %0d", exp_c.last, rsp_chunk_end);
               fail_count++;
            end
            if (rsp_run_last !== exp_c.run_last) begin
               $error("run_last exp %0d got %0d", exp_c.run_last, rsp_run_last);
               fail_count++;
            end
            if (rsp_text_done !== exp_c.done) begin
               $error("text_done exp %0d got %0d", exp_c.done, rsp_text_done);
               fail_count++;
            end
            if (rsp_overflow !== exp_c.ovf) begin
               $error("overflow exp %0d got %0d", exp_c.ovf, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      row_type   rows[$];
      row_type   r;
      int        n_sent;
      int        len;
      chunk_type ch;
      clear_text();
      // "it's a": contraction, space-led word; one-codepoint texts; mixed run
      rows = '{
         '{21'h69, 1'b0, 1'b0, 16'd0, 16'd0}, '{21'h74, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrApos, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrS, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrSpace, 1'b0, 1'b0, 16'd0, 16'd0}, '{21'h61, 1'b1, 1'b0, 16'd0, 16'd0},
         '{21'h37, 1'b1, 1'b1, 16'd0, 16'd1},
         '{21'h1FFFFF, 1'b1, 1'b1, 16'd0, 16'd1},
         '{21'h0, 1'b1, 1'b1, 16'd0, 16'd1},
         '{ChrApos, 1'b0, 1'b0, 16'd0, 16'd0}, '{21'h52, 1'b0, 1'b0, 16'd0, 16'd0},
         '{21'h45, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrSpace, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrSpace, 1'b0, 1'b0, 16'd0, 16'd0}, '{21'h21, 1'b0, 1'b0, 16'd0, 16'd0},
         '{21'h3F, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrCr, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrLf, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrTab, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrLf, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrSpace, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrSpace, 1'b0, 1'b0, 16'd0, 16'd0}, '{21'h39, 1'b0, 1'b0, 16'd0, 16'd0},
         '{ChrVt, 1'b0, 1'b0, 16'd0, 16'd0}, '{ChrFf, 1'b1, 1'b0, 16'd0, 16'd0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         r = rows[i];
         send_cp(r.cp, r.eot);
         if (r.typed) begin
            ch = chunk_queue[$];
            if (ch.first !== r.first) begin
               $error("table row %0d: chunk_start exp %0d got %0d", i, r.first, ch.first);
               fail_count++;
            end
            if (ch.last !== r.last) begin
               $error("table row %0d: chunk_end exp %0d got %0d", i, r.last, ch.last);
               fail_count++;
            end
         end
      end
      // random texts, mostly short
      n_sent = 0;
      while (n_sent < 245) begin
         len = $urandom_range(1, 24);
         for (int j = 0; j < len; j++) begin
            send_cp(pick_cp(), j == len - 1);
            n_sent++;
         end
      end
      req_valid <= 1'b0;
      feed_done = 1'b1;
   end

   initial begin
      wait (feed_done);
      while (chunk_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
design/pts_pkg.sv
design/pts_step.sv
design/pts_rsp_queue.sv
design/pretoken_splitter_core.sv
tb/testbench.sv
